// ===== src/log_truncation_barrier_table_assert.svh =====
// Assertion macros for the log truncation barrier table.
// Used by the modules that carry concurrent checks; needs a clock and reset in scope.
`ifndef LOG_TRUNCATION_BARRIER_TABLE_ASSERT_SVH
`define LOG_TRUNCATION_BARRIER_TABLE_ASSERT_SVH
// Same-cycle implication, disabled during reset.
`define LTB_ASSERT_IMPL(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define LTB_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);
`endif

// ===== src/ltb_pkg.sv =====
// Shared types and constants of the log truncation barrier table.
// No dependencies.
package ltb_pkg;
   localparam int BARRIER_DEPTH_DEFAULT = 1024;
   localparam int SEQ_W = 31;
   localparam int KIDX_W = 31;
   localparam int KOFF_W = 48;

   typedef enum logic [1:0] {
      STATUS_NOTED   = 2'd0,
      STATUS_TRUNC   = 2'd1,
      STATUS_NOTHING = 2'd2,
      STATUS_FULL    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WR_CLOSE,
      ST_WR_CHK,
      ST_SR_ISSUE,
      ST_SR_CMP,
      ST_TR_FIN,
      ST_TR_APPLY,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [SEQ_W-1:0]  seq;
      logic [KIDX_W-1:0] key_index;
      logic [KOFF_W-1:0] key_offset;
   } entry_type;
endpackage

// ===== src/ltb_if.sv =====
// Request and response channel interfaces of the log truncation barrier table.
// Depends on nothing but plain logic types.
interface ltb_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [30:0] seq_num;
   logic [30:0] flush_key_index;
   logic [47:0] flush_key_offset;
   logic        last_in_batch;
   modport source (output valid, req_type, seq_num, flush_key_index, flush_key_offset,
                   last_in_batch, input ready);
   modport sink (input valid, req_type, seq_num, flush_key_index, flush_key_offset,
                 last_in_batch, output ready);
endinterface

interface ltb_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] safe_key_index;
   logic [47:0] safe_key_offset;
   logic [31:0] truncated_seq;
   modport source (output valid, status, safe_key_index, safe_key_offset, truncated_seq,
                   input ready);
   modport sink (input valid, status, safe_key_index, safe_key_offset, truncated_seq,
                 output ready);
endinterface

// ===== src/log_truncation_barrier_table.sv =====
// Log truncation barrier table. One request at a time. A write completion that does
// not close its batch goes straight to its response; closing a batch passes a close
// state and, with live barriers, a check of the newest one. A truncate runs a binary
// search, probe by probe through the single read port, then reads and applies the result.
// Synchronous reset empties the table and batch and clears the safe point; no memory sweep.
module log_truncation_barrier_table #(
   parameter int BARRIER_DEPTH = ltb_pkg::BARRIER_DEPTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   ltb_req_if.sink   req_bus,
   ltb_rsp_if.source rsp_bus
);
   import ltb_pkg::*;
   `include "log_truncation_barrier_table_assert.svh"

   localparam int AW = (BARRIER_DEPTH > 1) ? $clog2(BARRIER_DEPTH) : 1;
   localparam int CW = $clog2(BARRIER_DEPTH + 1);

   state_type         state_ff, state_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              bempty_ff, bempty_in;
   logic [SEQ_W-1:0]  bseq_ff, bseq_in;
   logic [KIDX_W-1:0] bidx_ff, bidx_in;
   logic [KOFF_W-1:0] boff_ff, boff_in;
   logic              safe_valid_ff, safe_valid_in;
   logic [KIDX_W-1:0] safe_idx_ff, safe_idx_in;
   logic [KOFF_W-1:0] safe_off_ff, safe_off_in;
   logic              trunc_valid_ff, trunc_valid_in;
   logic [SEQ_W-1:0]  trunc_seq_ff, trunc_seq_in;
   logic [CW-1:0]     lo_ff, lo_in;
   logic [CW-1:0]     hi_ff, hi_in;
   logic [SEQ_W-1:0]  upto_ff, upto_in;
   status_type        status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [31:0]       rsp_sidx_ff, rsp_sidx_in;
   logic [47:0]       rsp_soff_ff, rsp_soff_in;
   logic [31:0]       rsp_tseq_ff, rsp_tseq_in;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   entry_type     wr_data, rd_data;
   logic [CW-1:0] mid;

   // Ring slot of the i-th live barrier; head + i stays below twice the depth.
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                             input logic [CW-1:0] i);
      logic [CW:0] sum;
      sum = (CW+1)'(head) + (CW+1)'(i);
      if (sum >= (CW+1)'(BARRIER_DEPTH)) begin
         sum = sum - (CW+1)'(BARRIER_DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   ltb_mem #(.DEPTH(BARRIER_DEPTH), .AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);

   assign req_bus.ready           = (state_ff == ST_IDLE);
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.status          = rsp_status_ff;
   assign rsp_bus.safe_key_index  = rsp_sidx_ff;
   assign rsp_bus.safe_key_offset = rsp_soff_ff;
   assign rsp_bus.truncated_seq   = rsp_tseq_ff;

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      bempty_in      = bempty_ff;
      bseq_in        = bseq_ff;
      bidx_in        = bidx_ff;
      boff_in        = boff_ff;
      safe_valid_in  = safe_valid_ff;
      safe_idx_in    = safe_idx_ff;
      safe_off_in    = safe_off_ff;
      trunc_valid_in = trunc_valid_ff;
      trunc_seq_in   = trunc_seq_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      upto_in        = upto_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_sidx_in    = rsp_sidx_ff;
      rsp_soff_in    = rsp_soff_ff;
      rsp_tseq_in    = rsp_tseq_ff;
      wr_en          = 1'b0;
      wr_addr        = slot_of(head_ff, count_ff);
      wr_data        = '{seq: bseq_ff, key_index: bidx_ff, key_offset: boff_ff};
      rd_en          = 1'b0;
      rd_addr        = slot_of(head_ff, mid);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               upto_in = req_bus.seq_num;
               if (!req_bus.req_type) begin
                  if (bempty_ff || (req_bus.seq_num > bseq_ff)) begin
                     bempty_in = 1'b0;
                     bseq_in   = req_bus.seq_num;
                     bidx_in   = req_bus.flush_key_index;
                     boff_in   = req_bus.flush_key_offset;
                  end
                  status_in = STATUS_NOTED;
                  state_in  = req_bus.last_in_batch ? ST_WR_CLOSE : ST_DONE;
               end else begin
                  lo_in    = '0;
                  hi_in    = count_ff;
                  state_in = ST_SR_ISSUE;
               end
            end
         end
         ST_WR_CLOSE: begin
            if (count_ff != '0) begin
               rd_en    = 1'b1;
               rd_addr  = slot_of(head_ff, count_ff - CW'(1));
               state_in = ST_WR_CHK;
            end else begin
               wr_en     = 1'b1;
               count_in  = count_ff + CW'(1);
               bempty_in = 1'b1;
               status_in = STATUS_NOTED;
               state_in  = ST_DONE;
            end
         end
         ST_WR_CHK: begin
            // Newest barrier already covers the batch: only its key moves forward.
            if (rd_data.seq >= bseq_ff) begin
               wr_en        = 1'b1;
               wr_addr      = slot_of(head_ff, count_ff - CW'(1));
               wr_data.seq  = rd_data.seq;
               status_in    = STATUS_NOTED;
            end else if (count_ff == CW'(BARRIER_DEPTH)) begin
               status_in = STATUS_FULL;
            end else begin
               wr_en     = 1'b1;
               count_in  = count_ff + CW'(1);
               status_in = STATUS_NOTED;
            end
            bempty_in = 1'b1;
            state_in  = ST_DONE;
         end
         ST_SR_ISSUE: begin
            if (lo_ff < hi_ff) begin
               rd_en    = 1'b1;
               state_in = ST_SR_CMP;
            end else begin
               state_in = ST_TR_FIN;
            end
         end
         ST_SR_CMP: begin
            if (rd_data.seq <= upto_ff) begin
               lo_in = mid + CW'(1);
            end else begin
               hi_in = mid;
            end
            state_in = ST_SR_ISSUE;
         end
         ST_TR_FIN: begin
            if (lo_ff == '0) begin
               status_in = STATUS_NOTHING;
               state_in  = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = slot_of(head_ff, lo_ff - CW'(1));
               state_in = ST_TR_APPLY;
            end
         end
         ST_TR_APPLY: begin
            safe_valid_in  = 1'b1;
            safe_idx_in    = rd_data.key_index;
            safe_off_in    = rd_data.key_offset;
            trunc_valid_in = 1'b1;
            trunc_seq_in   = rd_data.seq;
            head_in        = slot_of(head_ff, lo_ff);
            count_in       = count_ff - lo_ff;
            status_in      = STATUS_TRUNC;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            // Results leave through the response register once it is free.
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_sidx_in   = safe_valid_ff ? {1'b0, safe_idx_ff} : '1;
               rsp_soff_in   = safe_off_ff;
               rsp_tseq_in   = trunc_valid_ff ? {1'b0, trunc_seq_ff} : '1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         head_ff        <= '0;
         count_ff       <= '0;
         bempty_ff      <= 1'b1;
         safe_valid_ff  <= 1'b0;
         safe_off_ff    <= '0;
         trunc_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         head_ff        <= head_in;
         count_ff       <= count_in;
         bempty_ff      <= bempty_in;
         safe_valid_ff  <= safe_valid_in;
         safe_off_ff    <= safe_off_in;
         trunc_valid_ff <= trunc_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bseq_ff       <= bseq_in;
      bidx_ff       <= bidx_in;
      boff_ff       <= boff_in;
      safe_idx_ff   <= safe_idx_in;
      trunc_seq_ff  <= trunc_seq_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      upto_ff       <= upto_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sidx_ff   <= rsp_sidx_in;
      rsp_soff_ff   <= rsp_soff_in;
      rsp_tseq_ff   <= rsp_tseq_in;
   end

   `LTB_ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= CW'(BARRIER_DEPTH), "table count above depth")
   `LTB_ASSERT_IMPL(a_search_window, state_ff == ST_SR_CMP, (lo_ff < hi_ff) && (hi_ff <= count_ff), "search window broken")
   `LTB_ASSERT_IMPL(a_write_state, wr_en, state_ff == ST_WR_CLOSE || state_ff == ST_WR_CHK, "memory written outside batch close")
   `LTB_ASSERT_NEXT(a_rsp_load, state_ff == ST_DONE && (!rsp_valid_ff || rsp_bus.ready), rsp_valid_ff && state_ff == ST_IDLE, "response not loaded")
endmodule

// ===== src/ltb_mem.sv =====
// Barrier ring storage: one write port, one read port with registered data.
// Depends on ltb_pkg for the entry type.
module ltb_mem #(
   parameter int DEPTH = ltb_pkg::BARRIER_DEPTH_DEFAULT,
   parameter int AW = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  ltb_pkg::entry_type  wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output ltb_pkg::entry_type  rd_data
);
   import ltb_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
